// ===== hdl/alu16_pkg.sv =====
// ----------------------------------------------------------------------------
// alu16_pkg
// Shared opcodes, pipeline record and divider step for the 16-bit ALU.
// ----------------------------------------------------------------------------
package alu16_pkg;

  // Basic opcodes
  localparam logic [4:0] OP_SET = 5'h01;
  localparam logic [4:0] OP_ADD = 5'h02;
  localparam logic [4:0] OP_SUB = 5'h03;
  localparam logic [4:0] OP_MUL = 5'h04;
  localparam logic [4:0] OP_MLI = 5'h05;
  localparam logic [4:0] OP_DIV = 5'h06;
  localparam logic [4:0] OP_DVI = 5'h07;
  localparam logic [4:0] OP_MOD = 5'h08;
  localparam logic [4:0] OP_MDI = 5'h09;
  localparam logic [4:0] OP_AND = 5'h0a;
  localparam logic [4:0] OP_BOR = 5'h0b;
  localparam logic [4:0] OP_XOR = 5'h0c;
  localparam logic [4:0] OP_SHR = 5'h0d;
  localparam logic [4:0] OP_ASR = 5'h0e;
  localparam logic [4:0] OP_SHL = 5'h0f;
  localparam logic [4:0] OP_IFB = 5'h10;
  localparam logic [4:0] OP_IFC = 5'h11;
  localparam logic [4:0] OP_IFE = 5'h12;
  localparam logic [4:0] OP_IFN = 5'h13;
  localparam logic [4:0] OP_IFG = 5'h14;
  localparam logic [4:0] OP_IFA = 5'h15;
  localparam logic [4:0] OP_IFL = 5'h16;
  localparam logic [4:0] OP_IFU = 5'h17;
  localparam logic [4:0] OP_ADX = 5'h1a;
  localparam logic [4:0] OP_SBX = 5'h1b;
  localparam logic [4:0] OP_STI = 5'h1e;
  localparam logic [4:0] OP_STD = 5'h1f;

  // Index step codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  // Divider geometry: 32 quotient bits, 4 per stage
  localparam int DIV_BITS      = 32;
  localparam int STEPS_PER_STG = 4;
  localparam int DIV_STAGES    = DIV_BITS / STEPS_PER_STG;
  localparam int REM_STAGE     = 16 / STEPS_PER_STG;

  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] dq;   // dividend shifting out, quotient shifting in
  } div_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  opcode;
    logic [15:0] res;
    logic [15:0] cout;
    logic        wr;
    logic        wc;
    logic        fail;
    logic [1:0]  step;
    logic        resv;
    logic        neg_q;
    logic        neg_r;
    logic        a_zero;
    logic [15:0] dvsr;
    div_t        div;
    logic [15:0] rem16;
  } pipe_t;

  // One restoring division step
  function automatic div_t div_step(div_t d_in, logic [15:0] dvsr);
    logic [16:0] t;
    div_t        d_out;
    t = {d_in.rem, d_in.dq[31]};
    if (t >= {1'b0, dvsr}) begin
      d_out.rem = 16'(t - {1'b0, dvsr});
      d_out.dq  = {d_in.dq[30:0], 1'b1};
    end else begin
      d_out.rem = t[15:0];
      d_out.dq  = {d_in.dq[30:0], 1'b0};
    end
    return d_out;
  endfunction

endpackage

// ===== hdl/sixteen_bit_alu_with_overflow_word.sv =====
// ----------------------------------------------------------------------------
// sixteen_bit_alu_with_overflow_word
// Basic-instruction ALU with overflow word, fully pipelined.
// ----------------------------------------------------------------------------
// One instruction is taken per clock unless the output stalls, and its result
// passes one decode/execute stage, eight divider stages of four restoring steps
// each and one output register. Every opcode travels the same path, so order
// is kept. The 32-step long division for DIV/DVI/MOD/MDI sets the depth.
// A stall on the output holds the whole pipeline; s_tready is high whenever
// the output register is empty or being drained.
module sixteen_bit_alu_with_overflow_word (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[4:0], operand_a[20:5], operand_b[36:21], carry_in[52:37], zero pad
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result[15:0], write_result[16], carry_out[32:17], write_carry[33],
  // condition_failed[34], index_step[36:35], reserved_op[37], zero pad
  output logic [39:0] m_tdata
);

  logic [4:0]  opcode;
  logic [15:0] a, b, ex;
  logic        adv;
  logic [16:0] sum_ab;
  logic [17:0] sum_adx;
  logic signed [17:0] diff_sbx;
  logic [31:0] prod_u;
  logic signed [31:0] prod_s;
  logic [31:0] shr_v, shl_v;
  logic signed [31:0] asr_v;
  logic        signed_div;
  logic [15:0] mag_a, mag_b;
  alu16_pkg::pipe_t entry;
  alu16_pkg::pipe_t pipe [alu16_pkg::DIV_STAGES+1];
  alu16_pkg::pipe_t last;
  logic [15:0] q_hi, q_lo, out_res, out_cout;

  assign opcode = s_tdata[4:0];
  assign a      = s_tdata[20:5];
  assign b      = s_tdata[36:21];
  assign ex     = s_tdata[52:37];

  // Whole pipeline moves unless the output holds a result not yet taken
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Execute for all non-divide ops, plus divider setup
  always_comb begin
    sum_ab     = {1'b0, b} + {1'b0, a};
    sum_adx    = {2'b0, b} + {2'b0, a} + {2'b0, ex};
    diff_sbx   = $signed({2'b0, b}) - $signed({2'b0, a}) + $signed({2'b0, ex});
    prod_u     = {16'b0, b} * {16'b0, a};
    prod_s     = 32'($signed(b)) * 32'($signed(a));
    shr_v      = {b, 16'b0} >> a;
    asr_v      = $signed({b, 16'b0}) >>> a;
    shl_v      = {16'b0, b} << a;
    signed_div = (opcode == alu16_pkg::OP_DVI) || (opcode == alu16_pkg::OP_MDI);
    mag_a      = (signed_div && a[15]) ? 16'(-a) : a;
    mag_b      = (signed_div && b[15]) ? 16'(-b) : b;

    entry        = '0;
    entry.valid  = s_tvalid;
    entry.opcode = opcode;
    entry.cout   = ex;
    entry.neg_q  = signed_div && (a[15] ^ b[15]);
    entry.neg_r  = signed_div && b[15];
    entry.a_zero = (a == 16'd0);
    entry.dvsr   = mag_a;
    entry.div    = '{rem: 16'd0, dq: {mag_b, 16'd0}};

    unique case (opcode)
      alu16_pkg::OP_SET: begin entry.res = a; entry.wr = 1'b1; end
      alu16_pkg::OP_ADD: begin
        entry.res = sum_ab[15:0]; entry.cout = {15'd0, sum_ab[16]};
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_SUB: begin
        entry.res = 16'(b - a); entry.cout = (b < a) ? 16'hffff : 16'h0000;
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_MUL: begin
        entry.res = prod_u[15:0]; entry.cout = prod_u[31:16];
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_MLI: begin
        entry.res = prod_s[15:0]; entry.cout = prod_s[31:16];
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      // Divide ops: result filled at the end of the divider
      alu16_pkg::OP_DIV, alu16_pkg::OP_DVI: begin entry.wr = 1'b1; entry.wc = 1'b1; end
      alu16_pkg::OP_MOD, alu16_pkg::OP_MDI: begin entry.wr = 1'b1; end
      alu16_pkg::OP_AND: begin entry.res = b & a; entry.wr = 1'b1; end
      alu16_pkg::OP_BOR: begin entry.res = b | a; entry.wr = 1'b1; end
      alu16_pkg::OP_XOR: begin entry.res = b ^ a; entry.wr = 1'b1; end
      alu16_pkg::OP_SHR: begin
        entry.res = shr_v[31:16]; entry.cout = shr_v[15:0];
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_ASR: begin
        entry.res = asr_v[31:16]; entry.cout = asr_v[15:0];
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_SHL: begin
        entry.res = shl_v[15:0]; entry.cout = shl_v[31:16];
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_IFB: entry.fail = ((b & a) == 16'd0);
      alu16_pkg::OP_IFC: entry.fail = ((b & a) != 16'd0);
      alu16_pkg::OP_IFE: entry.fail = (b != a);
      alu16_pkg::OP_IFN: entry.fail = (b == a);
      alu16_pkg::OP_IFG: entry.fail = !(b > a);
      alu16_pkg::OP_IFA: entry.fail = !($signed(b) > $signed(a));
      alu16_pkg::OP_IFL: entry.fail = !(b < a);
      alu16_pkg::OP_IFU: entry.fail = !($signed(b) < $signed(a));
      alu16_pkg::OP_ADX: begin
        entry.res = sum_adx[15:0];
        entry.cout = (sum_adx > 18'h0ffff) ? 16'h0001 : 16'h0000;
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_SBX: begin
        entry.res = diff_sbx[15:0];
        if (diff_sbx < 0) begin
          entry.cout = 16'hffff;
        end else if (diff_sbx > $signed(18'h0ffff)) begin
          entry.cout = 16'h0001;
        end else begin
          entry.cout = 16'h0000;
        end
        entry.wr = 1'b1; entry.wc = 1'b1;
      end
      alu16_pkg::OP_STI: begin
        entry.res = a; entry.wr = 1'b1; entry.step = alu16_pkg::STEP_INC;
      end
      alu16_pkg::OP_STD: begin
        entry.res = a; entry.wr = 1'b1; entry.step = alu16_pkg::STEP_DEC;
      end
      default: entry.resv = 1'b1;
    endcase
  end

  // Execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (adv) begin
      pipe[0] <= entry;
    end
  end

  // Divider stages, four restoring steps each
  for (genvar k = 1; k <= alu16_pkg::DIV_STAGES; k++) begin : g_div
    alu16_pkg::pipe_t nxt;
    always_comb begin
      nxt = pipe[k-1];
      for (int s = 0; s < alu16_pkg::STEPS_PER_STG; s++) begin
        nxt.div = alu16_pkg::div_step(nxt.div, pipe[k-1].dvsr);
      end
      // integer remainder is ready after the first sixteen steps
      if (k == alu16_pkg::REM_STAGE) begin
        nxt.rem16 = nxt.div.rem;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k].valid <= 1'b0;
      end else if (adv) begin
        pipe[k] <= nxt;
      end
    end
  end

  // Sign fix and divide-by-zero for the divide ops
  assign last = pipe[alu16_pkg::DIV_STAGES];
  assign q_hi = last.div.dq[31:16];
  assign q_lo = last.div.dq[15:0];

  always_comb begin
    out_res  = last.res;
    out_cout = last.cout;
    if (last.opcode == alu16_pkg::OP_DIV || last.opcode == alu16_pkg::OP_DVI) begin
      out_res  = last.a_zero ? 16'd0 : (last.neg_q ? 16'(-q_hi) : q_hi);
      out_cout = last.a_zero ? 16'd0 : (last.neg_q ? 16'(-q_lo) : q_lo);
    end else if (last.opcode == alu16_pkg::OP_MOD || last.opcode == alu16_pkg::OP_MDI) begin
      out_res = last.a_zero ? 16'd0 : (last.neg_r ? 16'(-last.rem16) : last.rem16);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= last.valid;
      m_tdata  <= {2'b0, last.resv, last.step, last.fail, last.wc, out_cout,
                   last.wr, out_res};
    end
  end

`ifndef SYNTHESIS
  // An accepted transfer enters the execute stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> pipe[0].valid)
    else $error("accepted transfer did not enter the pipeline");

  // Reserved opcodes write nothing
  a_resv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[37] |-> !m_tdata[16] && !m_tdata[33] && !m_tdata[34])
    else $error("reserved opcode produced a write");

  // A failed test writes nothing
  a_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> !m_tdata[16] && !m_tdata[33])
    else $error("failed test produced a write");

  // Index step code is never the unused value
  a_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[36:35] != 2'd3)
    else $error("bad index step");
`endif

endmodule

// ===== tb/alu16_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu16_checker
// Watches both stream channels of the ALU, computes the expected result of
// every accepted instruction and compares it field by field with the output.
// ----------------------------------------------------------------------------
module alu16_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] res;
    logic        wr;
    logic [15:0] cout;
    logic        wc;
    logic        fail;
    logic [1:0]  step;
    logic        resv;
  } alu_out_t;

  alu_out_t expected_q[$];

  assign pending = expected_q.size();

  // Instruction semantics, operand treated as infinitely wide for shifts
  function automatic alu_out_t exec_insn(logic [4:0] op, logic [15:0] a,
                                         logic [15:0] b, logic [15:0] ex);
    alu_out_t   o;
    logic [31:0] p;
    logic signed [31:0] sa, sb, q32;
    logic signed [63:0] q64, t;
    logic [63:0] v;
    o = '0;
    o.cout = ex;
    sa = $signed({{16{a[15]}}, a});
    sb = $signed({{16{b[15]}}, b});
    case (op)
      alu16_pkg::OP_SET: begin o.res = a; o.wr = 1; end
      alu16_pkg::OP_ADD: begin
        p = {16'h0, b} + {16'h0, a};
        o.res = p[15:0]; o.cout = {15'h0, p[16]}; o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_SUB: begin
        o.res = b - a; o.cout = (b < a) ? 16'hffff : 16'h0; o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_MUL: begin
        p = {16'h0, b} * {16'h0, a};
        o.res = p[15:0]; o.cout = p[31:16]; o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_MLI: begin
        p = sb * sa; o.res = p[15:0]; o.cout = p[31:16]; o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_DIV: begin
        if (a != 0) begin
          o.res = b / a;
          p = {b, 16'h0} / {16'h0, a};
          o.cout = p[15:0];
        end else begin
          o.res = 0; o.cout = 0;
        end
        o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_DVI: begin
        if (a != 0) begin
          q32 = sb / sa;
          o.res = q32[15:0];
          q64 = (64'(sb) * 65536) / 64'(sa);
          o.cout = q64[15:0];
        end else begin
          o.res = 0; o.cout = 0;
        end
        o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_MOD: begin o.res = (a != 0) ? b % a : 16'h0; o.wr = 1; end
      alu16_pkg::OP_MDI: begin
        q32 = (a != 0) ? sb % sa : 0;
        o.res = q32[15:0]; o.wr = 1;
      end
      alu16_pkg::OP_AND: begin o.res = b & a; o.wr = 1; end
      alu16_pkg::OP_BOR: begin o.res = b | a; o.wr = 1; end
      alu16_pkg::OP_XOR: begin o.res = b ^ a; o.wr = 1; end
      alu16_pkg::OP_SHR, alu16_pkg::OP_ASR: begin
        // b sits above 16 fraction bits; sign-extend for arithmetic shift
        t = (op == alu16_pkg::OP_ASR) ? (64'(sb) <<< 16) : $signed({32'h0, b, 16'h0});
        if (a >= 64) t = (op == alu16_pkg::OP_ASR && t < 0) ? -64'sd1 : 64'sd0;
        else if (op == alu16_pkg::OP_ASR) t = t >>> a;
        else t = $signed($unsigned(t) >> a);
        o.res = t[31:16]; o.cout = t[15:0]; o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_SHL: begin
        if (a < 32) begin
          v = {48'h0, b} << a;
          o.res = v[15:0]; o.cout = v[31:16];
        end else begin
          o.res = 16'h0; o.cout = 16'h0;
        end
        o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_IFB: o.fail = (b & a) == 0;
      alu16_pkg::OP_IFC: o.fail = (b & a) != 0;
      alu16_pkg::OP_IFE: o.fail = !(b == a);
      alu16_pkg::OP_IFN: o.fail = !(b != a);
      alu16_pkg::OP_IFG: o.fail = !(b > a);
      alu16_pkg::OP_IFA: o.fail = !(sb > sa);
      alu16_pkg::OP_IFL: o.fail = !(b < a);
      alu16_pkg::OP_IFU: o.fail = !(sb < sa);
      alu16_pkg::OP_ADX: begin
        p = {16'h0, b} + {16'h0, a} + {16'h0, ex};
        o.res = p[15:0]; o.cout = (p > 32'hffff) ? 16'h1 : 16'h0;
        o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_SBX: begin
        q32 = $signed({16'h0, b}) - $signed({16'h0, a}) + $signed({16'h0, ex});
        o.res = q32[15:0];
        o.cout = (q32 < 0) ? 16'hffff : ((q32 > 32'sh0000ffff) ? 16'h1 : 16'h0);
        o.wr = 1; o.wc = 1;
      end
      alu16_pkg::OP_STI: begin o.res = a; o.wr = 1; o.step = alu16_pkg::STEP_INC; end
      alu16_pkg::OP_STD: begin o.res = a; o.wr = 1; o.step = alu16_pkg::STEP_DEC; end
      default: o.resv = 1;
    endcase
    return o;
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    alu_out_t got, want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_q.push_back(exec_insn(s_tdata[4:0], s_tdata[20:5],
                                       s_tdata[36:21], s_tdata[52:37]));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[16], m_tdata[32:17], m_tdata[33],
               m_tdata[34], m_tdata[36:35], m_tdata[37]};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected output %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"ERROR: res %h/%h wr %b/%b cout %h/%h wc %b/%b ",
                        "fail %b/%b step %d/%d resv %b/%b (exp/act)"},
                       want.res, got.res, want.wr, got.wr, want.cout, got.cout,
                       want.wc, got.wc, want.fail, got.fail, want.step, got.step,
                       want.resv, got.resv);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 16-bit ALU: directed corner instructions, then
// random bursts with gaps against a randomly stalling output.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  int          fail_count;
  int          pending;
  int          stall_mode = 0;

  always #2 clk = ~clk;

  sixteen_bit_alu_with_overflow_word DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  alu16_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stalls: alternate between always-ready and random-stall stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Hold one instruction until it transfers
  task automatic send_insn(logic [4:0] op, logic [15:0] a, logic [15:0] b,
                           logic [15:0] ex);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b0, ex, b, a, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    int sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: extremes, zero divisors, overflowing division, shifts
    send_insn(alu16_pkg::OP_SET, 16'hffff, 16'h0000, 16'h1234);
    send_insn(alu16_pkg::OP_ADD, 16'hffff, 16'hffff, 16'h0000);
    send_insn(alu16_pkg::OP_SUB, 16'h0001, 16'h0000, 16'h0000);
    send_insn(alu16_pkg::OP_MUL, 16'hffff, 16'hffff, 16'h0000);
    send_insn(alu16_pkg::OP_MLI, 16'h8000, 16'h8000, 16'h0000);
    send_insn(alu16_pkg::OP_DIV, 16'h0000, 16'h1234, 16'hffff);
    send_insn(alu16_pkg::OP_DVI, 16'h0000, 16'h8000, 16'hffff);
    send_insn(alu16_pkg::OP_DVI, 16'hffff, 16'h8000, 16'h0000);
    send_insn(alu16_pkg::OP_MOD, 16'h0000, 16'hffff, 16'h0000);
    send_insn(alu16_pkg::OP_MDI, 16'h0000, 16'h8000, 16'h0000);
    send_insn(alu16_pkg::OP_MDI, 16'h0007, 16'hfff9, 16'h0000);
    send_insn(alu16_pkg::OP_SHR, 16'hffff, 16'hffff, 16'h0000);
    send_insn(alu16_pkg::OP_ASR, 16'hffff, 16'h8000, 16'h0000);
    send_insn(alu16_pkg::OP_ASR, 16'h0010, 16'h8001, 16'h0000);
    send_insn(alu16_pkg::OP_SHL, 16'h001f, 16'hffff, 16'h0000);
    send_insn(alu16_pkg::OP_SHL, 16'h0020, 16'hffff, 16'h1234);
    send_insn(alu16_pkg::OP_IFA, 16'h8000, 16'h7fff, 16'h0000);
    send_insn(alu16_pkg::OP_IFU, 16'h7fff, 16'h8000, 16'h0000);
    send_insn(alu16_pkg::OP_ADX, 16'hffff, 16'hffff, 16'hffff);
    send_insn(alu16_pkg::OP_SBX, 16'hffff, 16'h0000, 16'h0000);
    send_insn(alu16_pkg::OP_SBX, 16'h0000, 16'hffff, 16'hffff);
    send_insn(alu16_pkg::OP_STI, 16'hffff, 16'h0000, 16'h0000);
    send_insn(alu16_pkg::OP_STD, 16'h0000, 16'hffff, 16'h0000);
    send_insn(5'h00, 16'hffff, 16'hffff, 16'hffff);
    send_insn(5'h1c, 16'h0000, 16'h0000, 16'h0000);

    // Drain fully before the random part
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);

    // Random bursts across all 32 opcodes
    sent = 0;
    while (sent < 850) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        send_insn(5'($urandom), pick_operand(), pick_operand(), pick_operand());
        sent++;
      end
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 12));
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
